/* rtl/pts_pkg.sv */
// pts_pkg: shared types, constants and helper functions of the pan/tilt slew limiter
// used by pts_div, pts_ctrl, pts_datapath and pan_tilt_slew_limiter
package pts_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam int ANG_W   = 16;
    localparam int LIM_W   = 9;
    localparam int CUT_W   = 10;
    localparam int GAIN_W  = 16;
    localparam int TICK_W  = 17;
    localparam int SPEED_W = 12;

    localparam int U_W        = 17;
    localparam int WRAP_W     = 24;
    localparam int NUM_W      = 20;
    localparam int M_W        = 24;
    localparam int SUM_W      = 33;
    localparam int SQRT_STEPS = 17;
    localparam int STEP_CNT_W = 5;
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 42;
    localparam int DIV_CNT_W  = 6;
    localparam int FILT_W     = 36;

    localparam logic [31:0] BIG_UNIT = 32'd2880000000;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_STANDING = 3'd0;
    localparam logic [2:0] REG_WALKING  = 3'd1;
    localparam logic [2:0] REG_CUTOFF   = 3'd2;
    localparam logic [2:0] REG_GAIN     = 3'd3;
    localparam logic [2:0] REG_TICK     = 3'd4;

    typedef struct packed {
        logic                    func;
        logic signed [ANG_W-1:0] target_yaw;
        logic signed [ANG_W-1:0] target_pitch;
        logic                    walking;
        logic [SPEED_W-1:0]      walk_speed;
    } item_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] yaw_out;
        logic signed [ANG_W-1:0] pitch_out;
        logic                    step_limited;
    } result_t;

    typedef struct packed {
        logic [LIM_W-1:0]  standing;
        logic [LIM_W-1:0]  walk_lim;
        logic [CUT_W-1:0]  cutoff;
        logic [GAIN_W-1:0] gain;
        logic [TICK_W-1:0] tick;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_WRAP,
        OP_FIX,
        OP_NUM,
        OP_PI,
        OP_TICK,
        OP_SQRT,
        OP_NSUM,
        OP_DIVM,
        OP_MTAKE,
        OP_DIVX,
        OP_XTAKE,
        OP_DIVY,
        OP_YTAKE,
        OP_FMUL,
        OP_FILT,
        OP_CMD,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic div_done;
        logic limited;
    } dp_status_t;

    function automatic logic [63:0] pi_q(input int f);
        return (PI_Q30 + (64'd1 << (29 - f))) >> (30 - f);
    endfunction

    function automatic logic [63:0] pi_fine(input int f);
        return (PI_Q30 + (64'd1 << (25 - f))) >> (26 - f);
    endfunction

    // number of compare-subtract steps that bring a 16-bit magnitude below two pi
    function automatic int wrap_steps(input int f);
        int          k;
        logic [63:0] tp;
        tp = pi_q(f) << 1;
        k  = 0;
        for (int i = 0; i < 17; i++) begin
            if ((tp << k) <= 64'd65535) begin
                k = k + 1;
            end
        end
        if (k == 0) begin
            k = 1;
        end
        return k;
    endfunction

    function automatic logic signed [ANG_W-1:0] sat16(input logic signed [FILT_W-1:0] x);
        if (x > 36'sd32767) begin
            return 16'sh7FFF;
        end else if (x < -36'sd32768) begin
            return 16'sh8000;
        end else begin
            return x[ANG_W-1:0];
        end
    endfunction

endpackage

/* rtl/pts_div.sv */
// pts_div: restoring divider, one quotient bit per cycle
// depends on pts_pkg for operand widths
module pts_div
    import pts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_NUM_W-1:0] quot,
    output logic                 done
);

    logic [DIV_NUM_W-1:0] n_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 q_bit;

    always_comb begin
        rem_sh = {rem_reg, n_reg[DIV_NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                n_reg    <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (q_bit) begin
                    rem_reg <= DIV_DEN_W'(rem_sh - {1'b0, den_reg});
                end else begin
                    rem_reg <= rem_sh[DIV_DEN_W-1:0];
                end
                n_reg   <= {n_reg[DIV_NUM_W-2:0], q_bit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot = n_reg;
    assign done = done_reg;

endmodule

/* rtl/pts_ctrl.sv */
// pts_ctrl: sequencer that steps the datapath through one control tick
// depends on pts_pkg for the op codes and status struct
module pts_ctrl
    import pts_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_op_t     op,
    input  dp_status_t status
);

    localparam int WRAP_STEPS = wrap_steps(ANGLE_FRAC_BITS);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRAP,
        ST_FIX,
        ST_NUM,
        ST_PI,
        ST_TICK,
        ST_SQRT,
        ST_NSUM,
        ST_DIVM_GO,
        ST_DIVM_WAIT,
        ST_CHK,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_FMUL,
        ST_FILT,
        ST_CMD,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op           = OP_IDLE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    cnt_next   = '0;
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                op       = OP_WRAP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(WRAP_STEPS - 1)) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                op         = OP_FIX;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                op         = OP_NUM;
                state_next = ST_PI;
            end
            ST_PI: begin
                op         = OP_PI;
                state_next = ST_TICK;
            end
            ST_TICK: begin
                op         = OP_TICK;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                op       = OP_SQRT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_NSUM;
                end
            end
            ST_NSUM: begin
                op         = OP_NSUM;
                state_next = ST_DIVM_GO;
            end
            ST_DIVM_GO: begin
                op         = OP_DIVM;
                state_next = ST_DIVM_WAIT;
            end
            ST_DIVM_WAIT: begin
                if (status.div_done) begin
                    op         = OP_MTAKE;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (status.limited) begin
                    state_next = ST_DIVX_GO;
                end else begin
                    state_next = ST_FMUL;
                end
            end
            ST_DIVX_GO: begin
                op         = OP_DIVX;
                state_next = ST_DIVX_WAIT;
            end
            ST_DIVX_WAIT: begin
                if (status.div_done) begin
                    op         = OP_XTAKE;
                    state_next = ST_DIVY_GO;
                end
            end
            ST_DIVY_GO: begin
                op         = OP_DIVY;
                state_next = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT: begin
                if (status.div_done) begin
                    op         = OP_YTAKE;
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL: begin
                op         = OP_FMUL;
                state_next = ST_FILT;
            end
            ST_FILT: begin
                op         = OP_FILT;
                state_next = ST_CMD;
            end
            ST_CMD: begin
                op         = OP_CMD;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    op           = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* rtl/pts_datapath.sv */
// pts_datapath: angle wrap, speed limit, square root, scaling and velocity filter
// depends on pts_pkg and pts_div
module pts_datapath
    import pts_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_op_t     op,
    input  item_t      item,
    input  cfg_t       cfg,
    output result_t    result,
    output dp_status_t status
);

    localparam logic [63:0] PI_V = pi_q(ANGLE_FRAC_BITS);
    localparam logic [WRAP_W-1:0] PI_A = PI_V[WRAP_W-1:0];
    localparam logic [WRAP_W-1:0] TP_A = WRAP_W'(PI_V << 1);
    localparam int WRAP_STEPS = wrap_steps(ANGLE_FRAC_BITS);
    localparam logic [WRAP_W-1:0] TP_TOP = WRAP_W'(TP_A << (WRAP_STEPS - 1));
    localparam logic [63:0] PIF_V = pi_fine(ANGLE_FRAC_BITS);
    localparam int PIF_W = $clog2(PIF_V + 64'd1);
    localparam logic [PIF_W-1:0] PIF = PIF_V[PIF_W-1:0];
    localparam int P1_W = NUM_W + PIF_W;
    localparam int HALF_W = (P1_W + 1) / 2;
    localparam int HI_W = P1_W - HALF_W;
    localparam int PROD_W = U_W + M_W;

    logic signed [ANG_W-1:0]  cmd_reg [2];
    logic signed [ANG_W-1:0]  vel_reg [2];
    logic                     neg_reg [2];
    logic [WRAP_W-1:0]        rabs_reg [2];
    logic [WRAP_W-1:0]        tpk_reg;
    logic signed [U_W-1:0]    u_reg [2];
    logic [2*U_W-1:0]         sq_reg [2];
    logic signed [2*U_W-1:0]  pv_reg [2];
    logic signed [2*U_W-1:0]  pu_reg [2];
    logic                     walk_reg;
    logic [SPEED_W-1:0]       speed_reg;
    logic [LIM_W+CUT_W-1:0]   num1_reg;
    logic [LIM_W+SPEED_W-1:0] num2_reg;
    logic                     cond_reg;
    logic [DIV_DEN_W-1:0]     big_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [P1_W-1:0]          p1_reg;
    logic [HALF_W+TICK_W-1:0] plo_reg;
    logic [HI_W+TICK_W-1:0]   phi_reg;
    logic [DIV_NUM_W-1:0]     nbig_reg;
    logic [SUM_W-1:0]         sx_reg;
    logic [SUM_W:0]           sr_reg;
    logic [SUM_W-1:0]         sbit_reg;
    logic [M_W-1:0]           m_reg;
    logic                     lim_reg;
    result_t                  out_reg;

    logic signed [U_W-1:0]    ld_d [2];
    logic signed [U_W-1:0]    ld_abs [2];
    logic signed [WRAP_W:0]   fix_w [2];
    logic signed [WRAP_W:0]   fix_u [2];
    logic                     cond;
    logic [CUT_W-1:0]         cut_diff;
    logic [CUT_W-1:0]         den;
    logic [SUM_W+1:0]         sq_rb;
    logic [M_W-1:0]           m_q;
    logic                     lim_c;
    logic                     sel_y;
    logic signed [U_W-1:0]    sc_u;
    logic [U_W-1:0]           sc_abs;
    logic [PROD_W-1:0]        sc_prod;
    logic signed [U_W-1:0]    q_s;
    logic signed [U_W-1:0]    q_new;
    logic [GAIN_W:0]          gain_m;
    logic signed [FILT_W-1:0] acc [2];
    logic                     div_start;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic [DIV_NUM_W-1:0]     div_quot;
    logic                     div_done;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (i == 0) begin
                ld_d[i] = item.func ? U_W'(item.target_yaw)
                                    : U_W'(item.target_yaw) - U_W'(cmd_reg[i]);
            end else begin
                ld_d[i] = item.func ? U_W'(item.target_pitch)
                                    : U_W'(item.target_pitch) - U_W'(cmd_reg[i]);
            end
            ld_abs[i] = (ld_d[i] < 0) ? -ld_d[i] : ld_d[i];
            if (neg_reg[i] && (rabs_reg[i] != '0)) begin
                fix_w[i] = $signed({1'b0, TP_A}) - $signed({1'b0, rabs_reg[i]});
            end else begin
                fix_w[i] = $signed({1'b0, rabs_reg[i]});
            end
            fix_u[i] = (fix_w[i] > $signed({1'b0, PI_A})) ? fix_w[i] - $signed({1'b0, TP_A})
                                                           : fix_w[i];
            acc[i] = FILT_W'(pv_reg[i]) + FILT_W'(pu_reg[i]) + 36'sd32768;
        end

        cond     = walk_reg && (cfg.cutoff != '0) && (speed_reg <= SPEED_W'(cfg.cutoff));
        cut_diff = cfg.cutoff - speed_reg[CUT_W-1:0];
        den      = cond ? cfg.cutoff : CUT_W'(1);

        sq_rb = (SUM_W+2)'(sr_reg) + (SUM_W+2)'(sbit_reg);

        m_q   = div_quot[M_W-1:0];
        lim_c = (sr_reg > (SUM_W+1)'(m_q))
             || ((sr_reg == (SUM_W+1)'(m_q)) && (sx_reg != '0));

        sel_y   = (op == OP_DIVY) || (op == OP_YTAKE);
        sc_u    = sel_y ? u_reg[1] : u_reg[0];
        sc_abs  = (sc_u < 0) ? $unsigned(-sc_u) : $unsigned(sc_u);
        sc_prod = PROD_W'(sc_abs) * PROD_W'(m_reg);
        q_s     = $signed(div_quot[U_W-1:0]);
        q_new   = (sc_u < 0) ? -q_s : q_s;

        gain_m = (GAIN_W+1)'(18'd65536 - 18'(cfg.gain));

        div_start = (op == OP_DIVM) || (op == OP_DIVX) || (op == OP_DIVY);
        if (op == OP_DIVM) begin
            div_num = nbig_reg;
            div_den = big_reg;
        end else begin
            div_num = DIV_NUM_W'(sc_prod) + DIV_NUM_W'(sr_reg >> 1);
            div_den = DIV_DEN_W'(sr_reg);
        end
    end

    pts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                cmd_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end else begin
            unique case (op)
                OP_IDLE: begin
                end
                OP_LOAD: begin
                    for (int i = 0; i < 2; i++) begin
                        neg_reg[i]  <= ld_d[i] < 0;
                        rabs_reg[i] <= WRAP_W'($unsigned(ld_abs[i]));
                    end
                    tpk_reg   <= TP_TOP;
                    walk_reg  <= item.walking;
                    speed_reg <= item.walk_speed;
                end
                OP_WRAP: begin
                    for (int i = 0; i < 2; i++) begin
                        if (rabs_reg[i] >= tpk_reg) begin
                            rabs_reg[i] <= rabs_reg[i] - tpk_reg;
                        end
                    end
                    tpk_reg <= tpk_reg >> 1;
                end
                OP_FIX: begin
                    for (int i = 0; i < 2; i++) begin
                        u_reg[i] <= fix_u[i][U_W-1:0];
                    end
                    num1_reg <= (LIM_W+CUT_W)'(cfg.standing) * (LIM_W+CUT_W)'(cut_diff);
                    num2_reg <= (LIM_W+SPEED_W)'(cfg.walk_lim) * (LIM_W+SPEED_W)'(speed_reg);
                    cond_reg <= cond;
                    big_reg  <= DIV_DEN_W'(BIG_UNIT) * DIV_DEN_W'(den);
                end
                OP_NUM: begin
                    num_reg <= cond_reg ? NUM_W'(NUM_W'(num1_reg) + NUM_W'(num2_reg))
                                        : NUM_W'(cfg.standing);
                end
                OP_PI: begin
                    p1_reg <= P1_W'(num_reg) * P1_W'(PIF);
                    for (int i = 0; i < 2; i++) begin
                        sq_reg[i] <= (2*U_W)'(u_reg[i]) * (2*U_W)'(u_reg[i]);
                    end
                end
                OP_TICK: begin
                    plo_reg  <= (HALF_W+TICK_W)'(p1_reg[HALF_W-1:0])
                              * (HALF_W+TICK_W)'(cfg.tick);
                    phi_reg  <= (HI_W+TICK_W)'(p1_reg[P1_W-1:HALF_W])
                              * (HI_W+TICK_W)'(cfg.tick);
                    sx_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]);
                    sr_reg   <= '0;
                    sbit_reg <= SUM_W'(1) << (SUM_W - 1);
                end
                OP_SQRT: begin
                    if ((SUM_W+2)'(sx_reg) >= sq_rb) begin
                        sx_reg <= SUM_W'((SUM_W+2)'(sx_reg) - sq_rb);
                        sr_reg <= (sr_reg >> 1) + (SUM_W+1)'(sbit_reg);
                    end else begin
                        sr_reg <= sr_reg >> 1;
                    end
                    sbit_reg <= sbit_reg >> 2;
                end
                OP_NSUM: begin
                    nbig_reg <= (DIV_NUM_W'(phi_reg) << HALF_W) + DIV_NUM_W'(plo_reg)
                              + DIV_NUM_W'(big_reg >> 1);
                end
                OP_DIVM: begin
                end
                OP_MTAKE: begin
                    m_reg   <= m_q;
                    lim_reg <= lim_c;
                end
                OP_DIVX: begin
                end
                OP_XTAKE: begin
                    u_reg[0] <= q_new;
                end
                OP_DIVY: begin
                end
                OP_YTAKE: begin
                    u_reg[1] <= q_new;
                end
                OP_FMUL: begin
                    for (int i = 0; i < 2; i++) begin
                        pv_reg[i] <= (2*U_W)'(vel_reg[i]) * (2*U_W)'($signed({1'b0, gain_m}));
                        pu_reg[i] <= (2*U_W)'(u_reg[i]) * (2*U_W)'($signed({1'b0, cfg.gain}));
                    end
                end
                OP_FILT: begin
                    for (int i = 0; i < 2; i++) begin
                        vel_reg[i] <= sat16(acc[i] >>> 16);
                    end
                end
                OP_CMD: begin
                    for (int i = 0; i < 2; i++) begin
                        cmd_reg[i] <= sat16(FILT_W'(cmd_reg[i]) + FILT_W'(vel_reg[i]));
                    end
                end
                OP_OUT: begin
                    out_reg.yaw_out      <= cmd_reg[0];
                    out_reg.pitch_out    <= cmd_reg[1];
                    out_reg.step_limited <= lim_reg;
                end
                default: begin
                end
            endcase
        end
    end

    assign result          = out_reg;
    assign status.div_done = div_done;
    assign status.limited  = lim_reg;

endmodule

/* rtl/pan_tilt_slew_limiter.sv */
// pan_tilt_slew_limiter: top level with configuration registers, sequencer and datapath
// depends on pts_pkg, pts_ctrl, pts_datapath
//
// channel   direction  transfer condition        payload
// s_        in         s_valid & s_ready          item_t
// m_        out        m_valid & m_ready          result_t
// apb       in/out     psel & penable & pwrite    32-bit register data
//
// an item takes longer when the step is scaled down, since the restoring divider
// then runs once for the limit and twice more to scale
// reset is synchronous and clears commands, velocities and handshake state
// a new item is taken while the previous result still waits on m_ready
module pan_tilt_slew_limiter
    import pts_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  item_t                 s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg_reg;
    dp_op_t     op;
    dp_status_t status;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.standing <= LIM_W'(120);
            cfg_reg.walk_lim <= LIM_W'(60);
            cfg_reg.cutoff   <= CUT_W'(40);
            cfg_reg.gain     <= GAIN_W'(6554);
            cfg_reg.tick     <= TICK_W'(10000);
        end else if (wr_en) begin
            case (reg_idx)
                REG_STANDING: cfg_reg.standing <= pwdata[LIM_W-1:0];
                REG_WALKING:  cfg_reg.walk_lim <= pwdata[LIM_W-1:0];
                REG_CUTOFF:   cfg_reg.cutoff   <= pwdata[CUT_W-1:0];
                REG_GAIN:     cfg_reg.gain     <= pwdata[GAIN_W-1:0];
                REG_TICK:     cfg_reg.tick     <= pwdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STANDING: prdata = APB_DATA_W'(cfg_reg.standing);
            REG_WALKING:  prdata = APB_DATA_W'(cfg_reg.walk_lim);
            REG_CUTOFF:   prdata = APB_DATA_W'(cfg_reg.cutoff);
            REG_GAIN:     prdata = APB_DATA_W'(cfg_reg.gain);
            REG_TICK:     prdata = APB_DATA_W'(cfg_reg.tick);
            default:      prdata = '0;
        endcase
    end

    pts_ctrl #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .op      (op),
        .status  (status)
    );

    pts_datapath #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .item    (s_item),
        .cfg     (cfg_reg),
        .result  (m_result),
        .status  (status)
    );

endmodule
